// ===== hdl/lmad_pkg.sv =====
package lmad_pkg;

   // Window geometry.
   localparam int WINDOW_LEN = 20;
   localparam int SLOT_W     = $clog2(WINDOW_LEN);

   // Field widths fixed by the interface.
   localparam int RAW_W    = 16;
   localparam int GAIN_W   = 24;
   localparam int THRESH_W = 16;
   localparam int FLOOR_W  = 2;
   localparam int SAMPLE_W = 24;
   localparam int CSR_W    = 24;
   localparam int CSR_IDX_W = 3;

   // Scaled sample product and its Q8 result before saturation.
   localparam int DIFF_W    = RAW_W + 1;
   localparam int PROD_W    = DIFF_W + GAIN_W + 1;
   localparam int GAIN_SHIFT = 16;
   localparam int SHIFTED_W = PROD_W - GAIN_SHIFT;

   // Running total of the window and the thresholds scaled to it.
   localparam int TOTAL_W  = SAMPLE_W + SLOT_W;
   localparam int SCALED_W = THRESH_W + SLOT_W;
   localparam int CMP_W    = TOTAL_W + 1;

   // Division of the total by the window length: multiply by a rounded-up
   // reciprocal and keep the top bits; exact for every magnitude below 2**MAG_W.
   localparam int MAG_W        = TOTAL_W;
   localparam int RECIP_SHIFT  = MAG_W + SLOT_W;
   localparam int RECIP_W      = MAG_W + 1;
   localparam longint RECIP_LONG = ((64'sd1 <<< RECIP_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_LONG);
   localparam int QPROD_W = MAG_W + RECIP_W;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   localparam logic [FLOOR_W-1:0] FLOOR_ONE = 2'd1;
   localparam logic [FLOOR_W-1:0] FLOOR_TWO = 2'd2;

   typedef enum logic [1:0] {
      CLS_BRAKING   = 2'd0,
      CLS_ACCEL     = 2'd1,
      CLS_STILL     = 2'd2,
      CLS_UNMATCHED = 2'd3
   } motion_class_type;

   typedef enum logic [1:0] {
      ARR_NONE      = 2'd0,
      ARR_FLOOR_ONE = 2'd1,
      ARR_FLOOR_TWO = 2'd2,
      ARR_UNCHANGED = 2'd3
   } arrival_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ACCEL_OFFSET   = 3'd0,
      REG_ACCEL_GAIN     = 3'd1,
      REG_MOTION_TRIGGER = 3'd2,
      REG_STILL_BAND     = 3'd3,
      REG_PRESENT_FLOOR  = 3'd4,
      REG_RISE_THRESHOLD = 3'd5,
      REG_FALL_THRESHOLD = 3'd6
   } csr_index_type;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USED_W = SAMPLE_W + 4;

endpackage

// ===== hdl/lmad_ram.sv =====
module lmad_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/lift_motion_arrival_detector.sv =====
// Lift motion and arrival detector. Each item on the req_ stream carries one raw
// vertical accelerometer sample and the current relative altitude; each item
// produces exactly one result item on the rsp_ stream, in order. The sample has
// the rest offset removed, is scaled by the gain (Q8 m/s^2, rounded toward minus
// infinity) and saturated to 24 bits, then enters a 20-entry window memory whose
// running total is kept. The window average is sorted into braking,
// accelerating, still or unmatched according to the starting floor; braking
// arms a latch, and a later still class clears it and reports the floor
// reached, judged from the altitude against the rise or fall threshold. The
// block takes one item every clock cycle while no result waits on rsp_tready;
// each result is registered in stages one to four and the output register.
// The rate is set by the read-modify-write of the running total in stage one:
// the window memory is read on accept and written back from stage one, so
// successive items touch different entries and need no forwarding. Per-entry
// valid flags make the window read as zero after reset, so no clearing pass is
// needed. The pipeline only stalls while a finished result waits on rsp_tready.
// Configuration registers are written through csr_we, csr_addr and csr_wdata
// and must only be changed while the block is idle.
module lift_motion_arrival_detector (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata: raw_accel [15:0], altitude_delta [31:16]
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [lmad_pkg::REQ_DATA_W-1:0]       req_tdata,
   // rsp_tdata: average_accel [23:0], motion_class [25:24], arrival [27:26],
   // zero fill [31:28]
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [lmad_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                  csr_we,
   input  logic [lmad_pkg::CSR_IDX_W-1:0]        csr_addr,
   input  logic [lmad_pkg::CSR_W-1:0]            csr_wdata
);

   import lmad_pkg::*;

   // Configuration registers.
   logic signed [RAW_W-1:0]    offset_ff;
   logic [GAIN_W-1:0]          gain_ff;
   logic [THRESH_W-1:0]        trigger_ff;
   logic [THRESH_W-1:0]        band_ff;
   logic [FLOOR_W-1:0]         floor_ff;
   logic signed [THRESH_W-1:0] rise_ff;
   logic signed [THRESH_W-1:0] fall_ff;

   // Thresholds scaled by the window length so that they compare with the total.
   logic [SCALED_W-1:0]        trig_scaled_ff;
   logic [SCALED_W-1:0]        band_scaled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff  <= '0;
         gain_ff    <= GAIN_W'(10048);
         trigger_ff <= THRESH_W'(128);
         band_ff    <= THRESH_W'(77);
         floor_ff   <= FLOOR_ONE;
         rise_ff    <= THRESH_W'(200);
         fall_ff    <= -THRESH_W'(200);
      end else if (csr_we) begin
         case (csr_addr)
            REG_ACCEL_OFFSET:   offset_ff  <= csr_wdata[RAW_W-1:0];
            REG_ACCEL_GAIN:     gain_ff    <= csr_wdata[GAIN_W-1:0];
            REG_MOTION_TRIGGER: trigger_ff <= csr_wdata[THRESH_W-1:0];
            REG_STILL_BAND:     band_ff    <= csr_wdata[THRESH_W-1:0];
            REG_PRESENT_FLOOR:  floor_ff   <= csr_wdata[FLOOR_W-1:0];
            REG_RISE_THRESHOLD: rise_ff    <= csr_wdata[THRESH_W-1:0];
            REG_FALL_THRESHOLD: fall_ff    <= csr_wdata[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      trig_scaled_ff <= SCALED_W'(trigger_ff) * SCALED_W'(WINDOW_LEN);
      band_scaled_ff <= SCALED_W'(band_ff) * SCALED_W'(WINDOW_LEN);
   end

   // Every stage moves forward together unless a finished result is waiting.
   logic advance;
   logic accept;

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && req_tready;

   // Stage 0: window slot, memory read and the gain multiplication.
   logic [SLOT_W-1:0]          slot_ff;
   logic [SLOT_W-1:0]          slot_in;
   logic [WINDOW_LEN-1:0]      entry_vld_ff;
   logic signed [RAW_W-1:0]    raw_accel;
   logic signed [RAW_W-1:0]    altitude_delta;
   logic signed [DIFF_W-1:0]   diff;
   logic signed [GAIN_W:0]     gain_signed;
   logic signed [PROD_W-1:0]   prod_in;

   assign raw_accel      = req_tdata[RAW_W-1:0];
   assign altitude_delta = req_tdata[2*RAW_W-1:RAW_W];
   assign diff           = DIFF_W'(raw_accel) - DIFF_W'(offset_ff);
   assign gain_signed    = $signed({1'b0, gain_ff});
   assign prod_in        = PROD_W'(diff) * PROD_W'(gain_signed);
   assign slot_in        = (slot_ff == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else if (accept) begin
         slot_ff <= slot_in;
      end
   end

   // Stage 1 registers.
   logic                       v1_ff;
   logic signed [PROD_W-1:0]   prod1_ff;
   logic signed [RAW_W-1:0]    alt1_ff;
   logic [SLOT_W-1:0]          slot1_ff;
   logic                       old_vld1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod1_ff    <= prod_in;
         alt1_ff     <= altitude_delta;
         slot1_ff    <= slot_ff;
         old_vld1_ff <= entry_vld_ff[slot_ff];
      end
   end

   // Window memory: read on accept, written back from stage 1.
   logic                       win_we;
   logic [SAMPLE_W-1:0]        win_rdata;
   logic signed [SAMPLE_W-1:0] sample;

   assign win_we = advance && v1_ff;

   lmad_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW_LEN)
   ) u_window_ram (
      .clock (clock),
      .we    (win_we),
      .waddr (slot1_ff),
      .wdata (sample),
      .re    (accept),
      .raddr (slot_ff),
      .rdata (win_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_vld_ff <= '0;
      end else if (win_we) begin
         entry_vld_ff[slot1_ff] <= 1'b1;
      end
   end

   // Stage 1: Q8 scaling with saturation and the running total update.
   logic signed [SHIFTED_W-1:0] shifted;
   logic signed [SAMPLE_W-1:0]  old_sample;
   logic signed [TOTAL_W-1:0]   total_ff;
   logic signed [TOTAL_W-1:0]   total_in;

   assign shifted = prod1_ff[PROD_W-1:GAIN_SHIFT];

   always_comb begin
      if (shifted > SHIFTED_W'(SAMPLE_MAX)) begin
         sample = SAMPLE_MAX;
      end else if (shifted < SHIFTED_W'(SAMPLE_MIN)) begin
         sample = SAMPLE_MIN;
      end else begin
         sample = shifted[SAMPLE_W-1:0];
      end
   end

   assign old_sample = old_vld1_ff ? $signed(win_rdata) : '0;
   assign total_in   = total_ff - TOTAL_W'(old_sample) + TOTAL_W'(sample);

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (win_we) begin
         total_ff <= total_in;
      end
   end

   // Stage 2 registers.
   logic                       v2_ff;
   logic signed [TOTAL_W-1:0]  total2_ff;
   logic signed [RAW_W-1:0]    alt2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         total2_ff <= total_in;
         alt2_ff   <= alt1_ff;
      end
   end

   // Stage 2: classification, braking latch and arrival, plus the magnitude
   // of the total for the division.
   logic signed [CMP_W-1:0] cmp_total;
   logic signed [CMP_W-1:0] cmp_trig;
   logic signed [CMP_W-1:0] cmp_band;
   logic                    moving_up;
   logic                    moving_down;
   logic                    standing;
   motion_class_type        cls;
   arrival_type             arrival;
   logic                    latch_ff;
   logic                    latch_in;
   logic [MAG_W-1:0]        mag;
   logic                    neg;

   assign cmp_total   = CMP_W'(total2_ff);
   assign cmp_trig    = $signed(CMP_W'(trig_scaled_ff));
   assign cmp_band    = $signed(CMP_W'(band_scaled_ff));
   assign moving_up   = cmp_total > cmp_trig;
   assign moving_down = cmp_total < -cmp_trig;
   assign standing    = (cmp_total < cmp_band) && (cmp_total > -cmp_band);

   always_comb begin
      cls = CLS_UNMATCHED;
      if (floor_ff == FLOOR_ONE) begin
         priority if (moving_up) begin
            cls = CLS_ACCEL;
         end else if (moving_down) begin
            cls = CLS_BRAKING;
         end else if (standing) begin
            cls = CLS_STILL;
         end else begin
            cls = CLS_UNMATCHED;
         end
      end else if (floor_ff == FLOOR_TWO) begin
         // Going down from floor two, the signs of acceleration and braking swap.
         priority if (moving_down) begin
            cls = CLS_ACCEL;
         end else if (moving_up) begin
            cls = CLS_BRAKING;
         end else if (standing) begin
            cls = CLS_STILL;
         end else begin
            cls = CLS_UNMATCHED;
         end
      end
   end

   always_comb begin
      latch_in = latch_ff;
      arrival  = ARR_NONE;
      if (cls == CLS_BRAKING && !latch_ff) begin
         latch_in = 1'b1;
      end else if (latch_ff && cls == CLS_STILL) begin
         latch_in = 1'b0;
         if (floor_ff == FLOOR_ONE) begin
            arrival = (alt2_ff > rise_ff) ? ARR_FLOOR_TWO : ARR_UNCHANGED;
         end else begin
            arrival = (alt2_ff < fall_ff) ? ARR_FLOOR_ONE : ARR_UNCHANGED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff <= 1'b0;
      end else if (advance && v2_ff) begin
         latch_ff <= latch_in;
      end
   end

   assign neg = total2_ff[TOTAL_W-1];
   assign mag = neg ? MAG_W'(-total2_ff) : MAG_W'(total2_ff);

   // Stage 3 registers and the reciprocal multiplication.
   logic                    v3_ff;
   logic [MAG_W-1:0]        mag3_ff;
   logic                    neg3_ff;
   motion_class_type        cls3_ff;
   arrival_type             arr3_ff;
   logic [QPROD_W-1:0]      qprod;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag3_ff <= mag;
         neg3_ff <= neg;
         cls3_ff <= cls;
         arr3_ff <= arrival;
      end
   end

   assign qprod = QPROD_W'(mag3_ff) * QPROD_W'(RECIP);

   // Stage 4 registers: quotient magnitude.
   logic                    v4_ff;
   logic [SAMPLE_W-1:0]     quot4_ff;
   logic                    neg4_ff;
   motion_class_type        cls4_ff;
   arrival_type             arr4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quot4_ff <= qprod[RECIP_SHIFT +: SAMPLE_W];
         neg4_ff  <= neg3_ff;
         cls4_ff  <= cls3_ff;
         arr4_ff  <= arr3_ff;
      end
   end

   // Output register: the quotient is truncated toward zero, so the sign is
   // reapplied to the magnitude.
   logic                    rsp_valid_ff;
   logic [SAMPLE_W-1:0]     avg_ff;
   motion_class_type        rsp_cls_ff;
   arrival_type             rsp_arr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         avg_ff     <= neg4_ff ? -quot4_ff : quot4_ff;
         rsp_cls_ff <= cls4_ff;
         rsp_arr_ff <= arr4_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_USED_W)'(0), rsp_arr_ff, rsp_cls_ff, avg_ff};

endmodule

// ===== hdl/lmad_checker.sv =====
module lmad_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [lmad_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import lmad_pkg::*;

   // A result that is not taken stays on the port unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   // The input side only holds off while a finished result is waiting.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low without output backpressure");

   // An arrival is only ever reported together with a still class.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[SAMPLE_W+3:SAMPLE_W+2] != ARR_NONE
         |-> rsp_tdata[SAMPLE_W+1:SAMPLE_W] == CLS_STILL)
      else $error("arrival reported outside a still class");

   // No result is valid right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind lift_motion_arrival_detector lmad_checker u_lmad_checker (.*);
